FILE: sv/rtpa_pkg.sv
// ----------------------------------------------------------------------------
// rtpa_pkg
// Shared types and constants for the region table page allocator.
// ----------------------------------------------------------------------------
package rtpa_pkg;

  localparam int unsigned MaxRegions = 32;
  localparam int unsigned PageShift  = 12;

  // table index and entry count widths
  localparam int unsigned IdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int unsigned CntW = $clog2(MaxRegions + 1);

  localparam logic [63:0] PageMask   = (64'd1 << PageShift) - 64'd1;
  localparam logic [7:0]  E820Usable = 8'd1;

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqAlloc = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StScan,
    StTail,
    StCalc,
    StFinish
  } state_e;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic        usable;
  } region_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic calc;
    logic finish_load;
    logic finish_alloc;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

FILE: sv/rtpa_ctrl.sv
// ----------------------------------------------------------------------------
// rtpa_ctrl
// Sequencer for load and allocate requests: accept, table scan, update, reply.
// ----------------------------------------------------------------------------
module rtpa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             req_type_i,
  input  rtpa_pkg::status_t st_i,
  output logic             in_ready_o,
  output rtpa_pkg::cmd_t   cmd_o
);

  rtpa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtpa_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rtpa_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = (req_type_i == rtpa_pkg::ReqAlloc) ? rtpa_pkg::StScan : rtpa_pkg::StLoad;
        end
      end
      rtpa_pkg::StLoad: begin
        if (st_i.out_free) begin
          state_d = rtpa_pkg::StIdle;
        end
      end
      rtpa_pkg::StScan: begin
        // nothing can fit: go straight to the reply
        if (st_i.skip) begin
          state_d = rtpa_pkg::StFinish;
        end else if (st_i.scan_last) begin
          state_d = rtpa_pkg::StTail;
        end
      end
      rtpa_pkg::StTail:   state_d = rtpa_pkg::StCalc;
      rtpa_pkg::StCalc:   state_d = rtpa_pkg::StFinish;
      rtpa_pkg::StFinish: begin
        if (st_i.out_free) begin
          state_d = rtpa_pkg::StIdle;
        end
      end
      default: state_d = rtpa_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      rtpa_pkg::StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      rtpa_pkg::StLoad:   cmd_o.finish_load  = st_i.out_free;
      rtpa_pkg::StScan:   cmd_o.scan_rd      = !st_i.skip;
      rtpa_pkg::StTail:   cmd_o            = '0;
      rtpa_pkg::StCalc:   cmd_o.calc         = 1'b1;
      rtpa_pkg::StFinish: cmd_o.finish_alloc = st_i.out_free;
      default:            cmd_o            = '0;
    endcase
  end

endmodule

FILE: sv/rtpa_dpath.sv
// ----------------------------------------------------------------------------
// rtpa_dpath
// Region table, scan compare, base/length update and the result register.
// ----------------------------------------------------------------------------
module rtpa_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtpa_pkg::cmd_t    cmd_i,
  output rtpa_pkg::status_t st_o,
  input  logic [4:0]        entry_index_i,
  input  logic [63:0]       entry_base_i,
  input  logic [63:0]       entry_length_i,
  input  logic [7:0]        entry_type_i,
  input  logic [63:0]       alloc_length_i,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       alloc_address_o,
  output logic              granted_o
);

  rtpa_pkg::region_t mem_q [rtpa_pkg::MaxRegions];

  logic [5:0]                  cnt_q;
  logic [rtpa_pkg::CntW-1:0]   lim_q, ptr_q;
  logic [rtpa_pkg::IdxW-1:0]   ld_idx_q, rd_idx_q, chosen_idx_q;
  logic                        ld_ok_q;
  rtpa_pkg::region_t           ld_region_q, rd_q, chosen_q;
  logic [63:0]                 len_q, addr_q, used_q;
  logic                        ovf_q, rd_vld_q, found_q;
  logic                        out_valid_q, granted_q;
  logic [63:0]                 alloc_address_q;

  logic [64:0]                 round_sum, len_diff;
  logic [rtpa_pkg::CntW-1:0]   lim_d, ptr_inc;
  logic                        hit;
  logic                        mem_we;
  logic [rtpa_pkg::IdxW-1:0]   wr_idx;
  rtpa_pkg::region_t           wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  // round the request up to a page, carry out means no region can fit
  assign round_sum = {1'b0, alloc_length_i} + {1'b0, rtpa_pkg::PageMask};
  assign lim_d     = (32'(cnt_q) > 32'(rtpa_pkg::MaxRegions)) ?
                     rtpa_pkg::CntW'(rtpa_pkg::MaxRegions) : rtpa_pkg::CntW'(cnt_q);
  assign ptr_inc   = ptr_q + rtpa_pkg::CntW'(1);

  assign st_o.skip      = ovf_q || (lim_q == '0);
  assign st_o.scan_last = (ptr_inc == lim_q);
  assign st_o.out_free  = !out_valid_q || out_ready_i;

  assign hit = rd_vld_q && rd_q.usable && (rd_q.length > len_q);

  // request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ld_idx_q           <= rtpa_pkg::IdxW'(entry_index_i);
      ld_region_q.base   <= entry_base_i;
      ld_region_q.length <= entry_length_i;
      ld_region_q.usable <= (entry_type_i == rtpa_pkg::E820Usable);
      len_q              <= round_sum[63:0] & ~rtpa_pkg::PageMask;
      lim_q              <= lim_d;
    end
    if (cmd_i.scan_rd) begin
      rd_idx_q <= ptr_q[rtpa_pkg::IdxW-1:0];
    end
    if (hit) begin
      chosen_idx_q <= rd_idx_q;
      chosen_q     <= rd_q;
    end
    if (cmd_i.calc) begin
      addr_q <= (chosen_q.base + rtpa_pkg::PageMask) & ~rtpa_pkg::PageMask;
      // len_q is page aligned, so adding the slack is an or and never overflows
      used_q <= len_q | (rtpa_pkg::PageMask & (64'd0 - chosen_q.base));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_ok_q  <= 1'b0;
      ovf_q    <= 1'b0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.accept) begin
        ld_ok_q <= (32'(entry_index_i) < 32'(rtpa_pkg::MaxRegions));
        ovf_q   <= round_sum[64];
        ptr_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          ptr_q <= ptr_inc;
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // update of the chosen entry, length clamps at zero
  assign len_diff = {1'b0, chosen_q.length} - {1'b0, used_q};

  always_comb begin
    mem_we  = 1'b0;
    wr_idx  = ld_idx_q;
    wr_data = ld_region_q;
    if (cmd_i.finish_load) begin
      mem_we = ld_ok_q;
    end else if (cmd_i.finish_alloc) begin
      mem_we         = found_q;
      wr_idx         = chosen_idx_q;
      wr_data.base   = chosen_q.base + used_q;
      wr_data.length = len_diff[64] ? 64'd0 : len_diff[63:0];
      wr_data.usable = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (cmd_i.scan_rd) begin
      rd_q <= mem_q[ptr_q[rtpa_pkg::IdxW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish_load || cmd_i.finish_alloc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_load) begin
      alloc_address_q <= 64'd0;
      granted_q       <= 1'b0;
    end else if (cmd_i.finish_alloc) begin
      alloc_address_q <= found_q ? addr_q : 64'd0;
      granted_q       <= found_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign alloc_address_o = alloc_address_q;
  assign granted_o       = granted_q;

  a_chosen_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (chosen_q.length > len_q))
    else $error("chosen region does not exceed the rounded length");

  a_ovf_no_find : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> !found_q)
    else $error("region found for a request that overflowed rounding");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (32'(rd_idx_q) < 32'(lim_q)))
    else $error("scan read beyond the region count");

  a_grant_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && granted_q) |-> ((alloc_address_q & rtpa_pkg::PageMask) == 64'd0))
    else $error("granted address is not page aligned");

  a_deny_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !granted_q) |-> (alloc_address_q == 64'd0))
    else $error("address nonzero on a result that is not granted");

endmodule

FILE: sv/region_table_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// region_table_page_allocator_unit
// Region table with a page-granular allocator that carves from the last
// usable region large enough for the request.
// ----------------------------------------------------------------------------
// A load request writes its entry and loads the result register once that
// register is free. An allocate request scans region_count entries, capped
// at the table size: the table sits in a single-port memory that is scanned
// one entry per cycle, followed by a step for the last compare, one to align
// the base and size the slack, and one to write the updated entry back and
// load the result register once it is free. An allocate whose size overflows
// on page rounding, or that sees a count of zero, skips the scan and replies
// directly. A new request is taken the cycle after the previous result enters
// the result register, even while that result is still waiting downstream.
module region_table_page_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [4:0]  entry_index_i,
  input  logic [63:0] entry_base_i,
  input  logic [63:0] entry_length_i,
  input  logic [7:0]  entry_type_i,
  input  logic [63:0] alloc_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] alloc_address_o,
  output logic        granted_o,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i
);

  rtpa_pkg::cmd_t    cmd;
  rtpa_pkg::status_t st;

  rtpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .st_i       (st),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  rtpa_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .entry_index_i   (entry_index_i),
    .entry_base_i    (entry_base_i),
    .entry_length_i  (entry_length_i),
    .entry_type_i    (entry_type_i),
    .alloc_length_i  (alloc_length_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .alloc_address_o (alloc_address_o),
    .granted_o       (granted_o)
  );

endmodule

FILE: tb/region_table_page_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// region_table_page_allocator_unit_tb
// Self-checking bench for the region table page allocator. A driver feeds
// load and allocate requests from a queue, and a shadow copy of the region
// table predicts every grant. A monitor compares each result with the
// oldest prediction. Both handshake sides idle at random, and the region
// count is swept between phases.
// ----------------------------------------------------------------------------
module region_table_page_allocator_unit_tb;

  localparam logic [63:0] AllOnes    = '1;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned PhaseItems = 140;

  typedef struct {
    logic        req_type;
    logic [4:0]  idx;
    logic [63:0] base;
    logic [63:0] len;
    logic [7:0]  etype;
    logic [63:0] want_len;
  } region_req_t;

  typedef struct {
    logic [63:0] addr;
    logic        granted;
  } grant_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        req_type_i     = rtpa_pkg::ReqLoad;
  logic [4:0]  entry_index_i  = '0;
  logic [63:0] entry_base_i   = '0;
  logic [63:0] entry_length_i = '0;
  logic [7:0]  entry_type_i   = '0;
  logic [63:0] alloc_length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [63:0] alloc_address_o;
  logic        granted_o;
  logic        cfg_we_i       = 1'b0;
  logic [5:0]  cfg_wdata_i    = '0;

  // shadow of the block state
  logic [63:0] tbl_base   [rtpa_pkg::MaxRegions];
  logic [63:0] tbl_len    [rtpa_pkg::MaxRegions];
  bit          tbl_usable [rtpa_pkg::MaxRegions];
  logic [5:0]  count_m = '0;

  region_req_t req_q[$];
  grant_t      grant_q[$];
  region_req_t cur_req;
  bit          slot_loaded [rtpa_pkg::MaxRegions];
  bit          in_quiet  = 1'b0;
  bit          out_quiet = 1'b0;
  int unsigned hold_cnt  = 0;
  int unsigned stall_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  region_table_page_allocator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .entry_index_i  (entry_index_i),
    .entry_base_i   (entry_base_i),
    .entry_length_i (entry_length_i),
    .entry_type_i   (entry_type_i),
    .alloc_length_i (alloc_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .alloc_address_o(alloc_address_o),
    .granted_o      (granted_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // updates the shadow table and returns the grant the block should give
  function automatic grant_t carve_region(region_req_t r);
    grant_t      g;
    logic [63:0] len;
    logic [63:0] b;
    logic [63:0] addr;
    logic [63:0] slack;
    logic [63:0] used;
    int unsigned limit;
    int unsigned pick;
    bit          found;
    g.addr    = '0;
    g.granted = 1'b0;
    found     = 1'b0;
    pick      = 0;
    if (r.req_type == rtpa_pkg::ReqLoad) begin
      tbl_base[r.idx]   = r.base;
      tbl_len[r.idx]    = r.len;
      tbl_usable[r.idx] = (r.etype == rtpa_pkg::E820Usable);
      return g;
    end
    // page rounding would pass the top of the address space
    if (r.want_len > ~rtpa_pkg::PageMask) return g;
    len   = (r.want_len + rtpa_pkg::PageMask) & ~rtpa_pkg::PageMask;
    limit = (32'(count_m) > rtpa_pkg::MaxRegions) ? rtpa_pkg::MaxRegions : 32'(count_m);
    for (int i = 0; i < limit; i++) begin
      if (tbl_usable[i] && tbl_len[i] > len) begin
        pick  = i;
        found = 1'b1;
      end
    end
    if (!found) return g;
    b     = tbl_base[pick];
    addr  = (b + rtpa_pkg::PageMask) & ~rtpa_pkg::PageMask;
    slack = addr - b;
    used  = (len > ~slack) ? AllOnes : len + slack;
    tbl_len[pick]  = (tbl_len[pick] > used) ? tbl_len[pick] - used : '0;
    tbl_base[pick] = b + used;
    g.addr    = addr;
    g.granted = 1'b1;
    return g;
  endfunction

  function automatic int unsigned draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    int unsigned gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      hold_cnt   <= 0;
    end else begin
      gap = hold_cnt;
      if (in_valid_i && in_ready_o) begin
        grant_q.push_back(carve_region(cur_req));
        gap = draw_gap(in_quiet);
      end
      if (in_valid_i && !in_ready_o) begin
        // request still pending, hold payload
      end else if (gap == 0 && req_q.size() != 0) begin
        cur_req = req_q.pop_front();
        req_type_i     <= cur_req.req_type;
        entry_index_i  <= cur_req.idx;
        entry_base_i   <= cur_req.base;
        entry_length_i <= cur_req.len;
        entry_type_i   <= cur_req.etype;
        alloc_length_i <= cur_req.want_len;
        in_valid_i     <= 1'b1;
        hold_cnt       <= 0;
      end else begin
        in_valid_i <= 1'b0;
        hold_cnt   <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    grant_t      want;
    int unsigned s;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cnt   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (grant_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected result: addr %h granted %b", alloc_address_o, granted_o);
          mismatch_cnt++;
        end else begin
          want = grant_q.pop_front();
          if (want.addr !== alloc_address_o || want.granted !== granted_o) begin
            if (mismatch_cnt < 10)
              $display("mismatch: expected addr %h granted %b, got addr %h granted %b",
                       want.addr, want.granted, alloc_address_o, granted_o);
            mismatch_cnt++;
          end
        end
        s = draw_gap(out_quiet);
        out_ready_i <= (s == 0);
        stall_cnt   <= s;
      end else if (stall_cnt > 0) begin
        stall_cnt   <= stall_cnt - 1;
        out_ready_i <= (stall_cnt == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("** region_table_page_allocator_unit: FAILED **");
      $finish;
    end
  end

  task automatic push_load(logic [4:0] idx, logic [63:0] base, logic [63:0] len,
                           logic [7:0] etype);
    region_req_t r;
    r.req_type = rtpa_pkg::ReqLoad;
    r.idx      = idx;
    r.base     = base;
    r.len      = len;
    r.etype    = etype;
    r.want_len = {$urandom, $urandom};
    slot_loaded[idx] = 1'b1;
    req_q.push_back(r);
  endtask

  task automatic push_alloc(logic [63:0] want_len);
    region_req_t r;
    r.req_type = rtpa_pkg::ReqAlloc;
    r.idx      = 5'($urandom_range(0, 31));
    r.base     = {$urandom, $urandom};
    r.len      = {$urandom, $urandom};
    r.etype    = 8'($urandom_range(0, 255));
    r.want_len = want_len;
    req_q.push_back(r);
  endtask

  function automatic region_req_t random_request();
    region_req_t r;
    r.req_type = ($urandom_range(0, 9) < 3) ? rtpa_pkg::ReqLoad : rtpa_pkg::ReqAlloc;
    r.idx      = 5'($urandom_range(0, 31));
    r.base     = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) r.base[11:0] = '0;
    if ($urandom_range(0, 9) == 0) r.base = AllOnes - 64'($urandom_range(0, 8191));
    case ($urandom_range(0, 3))
      0:       r.len = {$urandom, $urandom};
      1:       r.len = AllOnes - 64'($urandom_range(0, 65535));
      default: r.len = 64'($urandom_range(0, 1 << 20));
    endcase
    r.etype = ($urandom_range(0, 4) != 0) ? rtpa_pkg::E820Usable :
              8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       r.want_len = {$urandom, $urandom};
      // straddles the page rounding overflow boundary
      1:       r.want_len = AllOnes -
                            64'($urandom_range(0, 32'(2 * rtpa_pkg::PageMask)));
      2:       r.want_len = {44'($urandom_range(0, 255)), 20'h0} >> 8;
      default: r.want_len = 64'($urandom_range(0, 1 << 16));
    endcase
    return r;
  endfunction

  // every slot an allocate can scan must hold a loaded entry
  task automatic fill_prefix(int unsigned n);
    for (int i = 0; i < n && i < rtpa_pkg::MaxRegions; i++) begin
      if (!slot_loaded[i])
        push_load(5'(i), {$urandom, $urandom}, 64'($urandom_range(0, 1 << 20)),
                  rtpa_pkg::E820Usable);
    end
  endtask

  task automatic drain();
    while (req_q.size() != 0 || in_valid_i || grant_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_count(logic [5:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_m   = v;
    @(negedge clk_i);
  endtask

  initial begin
    region_req_t r;
    logic [5:0]  cnt;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // count is zero after reset: nothing can be granted
    push_alloc(64'd0);
    push_load(5'd0, 64'd0, AllOnes, rtpa_pkg::E820Usable);
    // base at the top wraps on page alignment
    push_load(5'd1, AllOnes, AllOnes, rtpa_pkg::E820Usable);
    push_load(5'd2, 64'h1001, 64'h5000, rtpa_pkg::E820Usable);
    push_load(5'd3, 64'h123, 64'h10000, 8'h00);
    push_load(5'd31, {$urandom, $urandom}, 64'h8000, 8'hFF);
    push_alloc(64'h1000);
    drain();

    write_count(6'd4);
    push_alloc(AllOnes);
    push_alloc(64'hFFFF_FFFF_FFFF_F001);
    push_alloc(64'hFFFF_FFFF_FFFF_F000);
    push_alloc(64'd0);
    push_alloc(64'h4000);
    push_alloc(64'd1);
    push_alloc(64'h1001);
    push_load(5'd2, 64'h1000, 64'h3000, rtpa_pkg::E820Usable);
    push_alloc(64'h2000);
    push_alloc(64'h3000);
    // slack pushes the consumed size past the region length
    push_load(5'd2, 64'h1001, 64'h1800, rtpa_pkg::E820Usable);
    push_alloc(64'h1000);
    push_load(5'd1, 64'h0, 64'h0, rtpa_pkg::E820Usable);
    push_load(5'd0, 64'h7000, 64'h1000, rtpa_pkg::E820Usable);
    push_alloc(64'h0);
    drain();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       cnt = 6'd32;
        1:       cnt = 6'd63;
        2:       cnt = 6'd1;
        3:       cnt = 6'd33;
        4:       cnt = 6'd0;
        5:       cnt = 6'd16;
        default: cnt = 6'($urandom_range(0, 63));
      endcase
      write_count(cnt);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      fill_prefix(32'(cnt));
      for (int k = 0; k < PhaseItems; k++) begin
        r = random_request();
        if (r.req_type == rtpa_pkg::ReqLoad) slot_loaded[r.idx] = 1'b1;
        req_q.push_back(r);
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** region_table_page_allocator_unit: PASSED **");
    end else begin
      $display("** region_table_page_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
